// File: hdl/aho_corasick_first_match_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-match string scanner
// Shared property shapes, clocked on i_clk, off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef AHO_CORASICK_FIRST_MATCH_CORE_DEFINES_SVH
`define AHO_CORASICK_FIRST_MATCH_CORE_DEFINES_SVH

// same-cycle implication
`define ACFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/acfm_pkg.sv
// ---------------------------------------------------------------------------
// acfm_pkg
// Shared codes and control/status types of the first-match scanner.
// ---------------------------------------------------------------------------
package acfm_pkg;

    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_BUILD   = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    localparam logic [2:0] ST_NO_MATCH  = 3'd0;
    localparam logic [2:0] ST_MATCH     = 3'd1;
    localparam logic [2:0] ST_STORED    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BUILT     = 3'd4;
    localparam logic [2:0] ST_ORDER     = 3'd5;
    localparam logic [2:0] ST_SATURATED = 3'd6;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_P_RD, S_P_FIN,
        S_B_RRD, S_B_RCHK, S_B_POP, S_B_N, S_B_K, S_B_FK, S_B_FG,
        S_B_F, S_B_FA, S_B_ARD, S_B_ACHK,
        S_T_RD, S_T_ACC, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_P_LOAD, OP_B_LOAD, OP_T_LOAD, OP_ERR,
        OP_P_RD, OP_P_FIN,
        OP_B_RRD, OP_B_RCHK, OP_B_POP, OP_B_N, OP_B_K, OP_B_FK, OP_B_FG,
        OP_B_F, OP_B_FA, OP_B_ARD, OP_B_ACHK, OP_B_DONE,
        OP_T_RD, OP_T_ACC, OP_EMIT
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] act;
        logic       last;
        logic       built;
        logic       dropping;
        logic       cursor_zero;
        logic       b_ok;
        logic       sym_last;
        logic       head_lt_tail;
        logic       k_zero;
        logic       has_result;
        logic       out_free;
    } t_stat;

endpackage

// File: hdl/acfm_if.sv
// ---------------------------------------------------------------------------
// acfm_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface acfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, action, data_byte, last, input ready);
    modport sink   (input valid, action, data_byte, last, output ready);
endinterface

interface acfm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  match_start;
    logic [9:0]  match_length;
    logic [31:0] line_number;
    modport source (output valid, status, match_start, match_length, line_number,
                    input ready);
    modport sink   (input valid, status, match_start, match_length, line_number,
                    output ready);
endinterface

// File: hdl/acfm_ctrl.sv
// ---------------------------------------------------------------------------
// acfm_ctrl
// Sequencer: picks the datapath operation for each cycle.
// ---------------------------------------------------------------------------
module acfm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  acfm_pkg::t_stat  i_stat,
    output acfm_pkg::t_cmd   o_cmd
);
    import acfm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_CLR;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_valid) begin
                    case (i_stat.act)
                        ACT_PATTERN: begin
                            if (i_stat.built) begin
                                o_cmd.op = OP_ERR;
                                n_state  = S_EMIT;
                            end else begin
                                o_cmd.op = OP_P_LOAD;
                                n_state  = (!i_stat.dropping && i_stat.b_ok) ? S_P_RD : S_P_FIN;
                            end
                        end
                        ACT_BUILD: begin
                            if (i_stat.built || !i_stat.cursor_zero || i_stat.dropping) begin
                                o_cmd.op = OP_ERR;
                                n_state  = S_EMIT;
                            end else begin
                                o_cmd.op = OP_B_LOAD;
                                n_state  = S_B_RRD;
                            end
                        end
                        ACT_TEXT: begin
                            if (!i_stat.built) begin
                                o_cmd.op = OP_ERR;
                                n_state  = S_EMIT;
                            end else begin
                                o_cmd.op = OP_T_LOAD;
                                n_state  = S_T_RD;
                            end
                        end
                        default: begin
                            o_cmd.op = OP_ERR;
                            n_state  = S_EMIT;
                        end
                    endcase
                end
            end
            S_P_RD: begin
                o_cmd.op = OP_P_RD;
                n_state  = S_P_FIN;
            end
            S_P_FIN: begin
                o_cmd.op = OP_P_FIN;
                n_state  = i_stat.has_result ? S_EMIT : S_IDLE;
            end
            S_B_RRD: begin
                o_cmd.op = OP_B_RRD;
                n_state  = S_B_RCHK;
            end
            S_B_RCHK: begin
                o_cmd.op = OP_B_RCHK;
                n_state  = i_stat.sym_last ? S_B_POP : S_B_RRD;
            end
            S_B_POP: begin
                if (i_stat.head_lt_tail) begin
                    o_cmd.op = OP_B_POP;
                    n_state  = S_B_N;
                end else begin
                    o_cmd.op = OP_B_DONE;
                    n_state  = S_EMIT;
                end
            end
            S_B_N: begin
                o_cmd.op = OP_B_N;
                n_state  = S_B_K;
            end
            S_B_K: begin
                o_cmd.op = OP_B_K;
                n_state  = i_stat.k_zero ? S_B_F : S_B_FK;
            end
            S_B_FK: begin
                o_cmd.op = OP_B_FK;
                n_state  = S_B_FG;
            end
            S_B_FG: begin
                o_cmd.op = OP_B_FG;
                n_state  = S_B_F;
            end
            S_B_F: begin
                o_cmd.op = OP_B_F;
                n_state  = S_B_FA;
            end
            S_B_FA: begin
                o_cmd.op = OP_B_FA;
                n_state  = S_B_ARD;
            end
            S_B_ARD: begin
                o_cmd.op = OP_B_ARD;
                n_state  = S_B_ACHK;
            end
            S_B_ACHK: begin
                o_cmd.op = OP_B_ACHK;
                n_state  = i_stat.sym_last ? S_B_POP : S_B_ARD;
            end
            S_T_RD: begin
                o_cmd.op = OP_T_RD;
                n_state  = S_T_ACC;
            end
            S_T_ACC: begin
                o_cmd.op = OP_T_ACC;
                n_state  = i_stat.has_result ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/acfm_datapath.sv
// ---------------------------------------------------------------------------
// acfm_datapath
// Trie/automaton memories, cursors, BFS queue and result registers.
// ---------------------------------------------------------------------------
module acfm_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 256,
    parameter int MAX_LINE  = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acfm_pkg::t_cmd   i_cmd,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    input  logic             i_out_ready,
    output acfm_pkg::t_stat  o_stat,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [9:0]       o_match_start,
    output logic [9:0]       o_match_length,
    output logic [31:0]      o_line_number
);
    import acfm_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int NSLOT = MAX_NODES * ALPHABET;
    localparam int GW    = $clog2(NSLOT);
    localparam int SW    = $clog2(ALPHABET);
    localparam int LW    = $clog2(MAX_LINE + 1);

    function automatic logic [GW-1:0] f_slot(input logic [NW-1:0] node,
                                             input logic [7:0] sym);
        f_slot = GW'(node) * GW'(ALPHABET) + GW'(sym);
    endfunction

    // memories
    logic [NW-1:0] m_goto   [NSLOT];
    logic [NW-1:0] m_fail   [MAX_NODES];
    logic [NW-1:0] m_parent [MAX_NODES];
    logic [7:0]    m_nbyte  [MAX_NODES];
    logic [NW-1:0] m_queue  [MAX_NODES];
    logic [NW:0]   m_acc    [MAX_NODES];   // {hit, length}

    logic          g_we;
    logic [GW-1:0] g_wa, g_ra_a, g_ra_b;
    logic [NW-1:0] g_wd, g_rda, g_rdb;
    logic          f_we;
    logic [NW-1:0] f_wa, f_wd, f_ra, f_rd;
    logic          pn_we;
    logic [NW-1:0] pn_wa, pn_wd, pn_ra, p_rd;
    logic [7:0]    nb_wd, nb_rd;
    logic          q_we;
    logic [NW-1:0] q_wd, q_rd;
    logic          a_we;
    logic [NW-1:0] a_wa, a_ra;
    logic [NW:0]   a_wd, a_rd;

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            m_goto[g_wa] <= g_wd;
        end
        g_rda <= m_goto[g_ra_a];
        g_rdb <= m_goto[g_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            m_fail[f_wa] <= f_wd;
        end
        f_rd <= m_fail[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pn_we) begin
            m_parent[pn_wa] <= pn_wd;
            m_nbyte[pn_wa]  <= nb_wd;
        end
        p_rd  <= m_parent[pn_ra];
        nb_rd <= m_nbyte[pn_ra];
    end

    // registers
    logic [GW:0]   r_clr, n_clr;
    logic [NW:0]   r_count, n_count;
    logic [NW-1:0] r_cursor, n_cursor, r_depth, n_depth;
    logic          r_dropping, n_dropping;
    logic [2:0]    r_dstat, n_dstat;
    logic          r_built, n_built;
    logic [NW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_lbs, n_lbs;
    logic          r_matched, n_matched;
    logic [31:0]   r_line, n_line;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last, r_search, n_search, r_sat, n_sat;
    logic [SW-1:0] r_sym, n_sym;
    logic [NW:0]   r_head, n_head, r_tail, n_tail;
    logic [NW-1:0] r_n, n_n, r_f, n_f;
    logic [7:0]    r_nb, n_nb;
    logic          r_acc_n, n_acc_n;
    logic          r_res_has, n_res_has;
    logic [2:0]    r_res_st, n_res_st;
    logic [9:0]    r_res_start, n_res_start, r_res_len, n_res_len;
    logic [31:0]   r_res_line, n_res_line;
    logic          r_ov, n_ov;
    logic [2:0]    r_o_st, n_o_st;
    logic [9:0]    r_o_start, n_o_start, r_o_len, n_o_len;
    logic [31:0]   r_o_line, n_o_line;

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_queue[r_tail[NW-1:0]] <= q_wd;
        end
        q_rd <= m_queue[r_head[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            m_acc[a_wa] <= a_wd;
        end
        a_rd <= m_acc[a_ra];
    end

    logic          b_ok_in, b_ok_r, t_hit, tail_room;
    logic [NW-1:0] t_node;
    logic [31:0]   t_len, t_idx1, t_start;

    always_comb begin
        b_ok_in   = {1'b0, i_data_byte} < 9'(ALPHABET);
        b_ok_r    = {1'b0, r_byte} < 9'(ALPHABET);
        tail_room = r_tail < (NW+1)'(MAX_NODES);
        t_node    = b_ok_r ? g_rda : '0;
        t_hit     = r_search && a_rd[NW];
        t_len     = 32'(a_rd[NW-1:0]);
        t_idx1    = 32'(r_lbs) + 32'd1;
        t_start   = (t_len <= t_idx1) ? (t_idx1 - t_len) : 32'd0;

        n_clr = r_clr; n_count = r_count; n_cursor = r_cursor; n_depth = r_depth;
        n_dropping = r_dropping; n_dstat = r_dstat; n_built = r_built;
        n_cur = r_cur; n_lbs = r_lbs; n_matched = r_matched; n_line = r_line;
        n_byte = r_byte; n_last = r_last; n_search = r_search; n_sat = r_sat;
        n_sym = r_sym; n_head = r_head; n_tail = r_tail;
        n_n = r_n; n_f = r_f; n_nb = r_nb; n_acc_n = r_acc_n;
        n_res_has = r_res_has; n_res_st = r_res_st; n_res_start = r_res_start;
        n_res_len = r_res_len; n_res_line = r_res_line;
        n_ov = r_ov; n_o_st = r_o_st; n_o_start = r_o_start;
        n_o_len = r_o_len; n_o_line = r_o_line;

        g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra_a = '0; g_ra_b = '0;
        f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
        pn_we = 1'b0; pn_wa = '0; pn_wd = '0; nb_wd = '0; pn_ra = '0;
        q_we = 1'b0; q_wd = '0;
        a_we = 1'b0; a_wa = '0; a_wd = '0; a_ra = '0;

        if (i_out_ready) begin
            n_ov = 1'b0;
        end

        case (i_cmd.op)
            OP_CLR: begin
                g_we  = 1'b1;
                g_wa  = r_clr[GW-1:0];
                if (r_clr < (GW+1)'(MAX_NODES)) begin
                    a_we = 1'b1;
                    a_wa = r_clr[NW-1:0];
                end
                n_clr = r_clr + 1'b1;
            end
            OP_P_LOAD: begin
                n_byte = i_data_byte;
                n_last = i_last;
                if (!r_dropping && !b_ok_in) begin
                    n_dropping = 1'b1;
                    n_dstat    = ST_STORED;
                end
                g_ra_a = f_slot(r_cursor, i_data_byte);
            end
            OP_P_RD: begin
                if (g_rda == '0) begin
                    if (r_count >= (NW+1)'(MAX_NODES)) begin
                        n_dropping = 1'b1;
                        n_dstat    = ST_FULL;
                    end else begin
                        g_we     = 1'b1;
                        g_wa     = f_slot(r_cursor, r_byte);
                        g_wd     = r_count[NW-1:0];
                        pn_we    = 1'b1;
                        pn_wa    = r_count[NW-1:0];
                        pn_wd    = r_cursor;
                        nb_wd    = r_byte;
                        n_count  = r_count + 1'b1;
                        n_cursor = r_count[NW-1:0];
                        n_depth  = r_depth + 1'b1;
                    end
                end else begin
                    n_cursor = g_rda;
                    n_depth  = r_depth + 1'b1;
                end
            end
            OP_P_FIN: begin
                if (r_last) begin
                    n_res_has   = 1'b1;
                    n_res_st    = r_dropping ? r_dstat : ST_STORED;
                    n_res_start = '0;
                    n_res_len   = '0;
                    n_res_line  = '0;
                    if (!r_dropping) begin
                        a_we = 1'b1;
                        a_wa = r_cursor;
                        a_wd = {1'b1, r_depth};
                    end
                    n_cursor   = '0;
                    n_depth    = '0;
                    n_dropping = 1'b0;
                end
            end
            OP_ERR: begin
                n_res_has   = 1'b1;
                n_res_st    = ST_ORDER;
                n_res_start = '0;
                n_res_len   = '0;
                n_res_line  = '0;
            end
            OP_B_LOAD: begin
                n_sym  = '0;
                n_head = '0;
                n_tail = '0;
            end
            OP_B_RRD: begin
                g_ra_a = f_slot('0, 8'(r_sym));
            end
            OP_B_RCHK: begin
                if (g_rda != '0 && tail_room) begin
                    f_we   = 1'b1;
                    f_wa   = g_rda;
                    q_we   = 1'b1;
                    q_wd   = g_rda;
                    n_tail = r_tail + 1'b1;
                end
                n_sym = r_sym + 1'b1;
            end
            OP_B_POP: begin
                n_head = r_head + 1'b1;
            end
            OP_B_N: begin
                n_n   = q_rd;
                pn_ra = q_rd;
                a_ra  = q_rd;
            end
            OP_B_K: begin
                n_acc_n = a_rd[NW];
                n_nb    = nb_rd;
                f_ra    = p_rd;
                if (p_rd == '0) begin
                    n_f = '0;
                end
            end
            OP_B_FK: begin
                g_ra_a = f_slot(f_rd, r_nb);
            end
            OP_B_FG: begin
                n_f = g_rda;
            end
            OP_B_F: begin
                f_we  = 1'b1;
                f_wa  = r_n;
                f_wd  = r_f;
                a_ra  = r_f;
                n_sym = '0;
            end
            OP_B_FA: begin
                if (!r_acc_n && a_rd[NW]) begin
                    a_we = 1'b1;
                    a_wa = r_n;
                    a_wd = a_rd;
                end
            end
            OP_B_ARD: begin
                g_ra_a = f_slot(r_n, 8'(r_sym));
                g_ra_b = f_slot(r_f, 8'(r_sym));
            end
            OP_B_ACHK: begin
                if (g_rda != '0) begin
                    if (tail_room) begin
                        q_we   = 1'b1;
                        q_wd   = g_rda;
                        n_tail = r_tail + 1'b1;
                    end
                end else begin
                    g_we = 1'b1;
                    g_wa = f_slot(r_n, 8'(r_sym));
                    g_wd = g_rdb;
                end
                n_sym = r_sym + 1'b1;
            end
            OP_B_DONE: begin
                n_built     = 1'b1;
                n_res_has   = 1'b1;
                n_res_st    = ST_BUILT;
                n_res_start = '0;
                n_res_len   = '0;
                n_res_line  = '0;
            end
            OP_T_LOAD: begin
                n_byte = i_data_byte;
                n_last = i_last;
                if (r_lbs == '0 && r_line != '1) begin
                    n_line = r_line + 1'b1;
                end
                n_search = !r_matched && (r_lbs < LW'(MAX_LINE));
                n_sat    = !r_matched && (r_lbs >= LW'(MAX_LINE));
                g_ra_a   = f_slot(r_cur, i_data_byte);
            end
            OP_T_RD: begin
                if (r_search) begin
                    n_cur = t_node;
                    a_ra  = t_node;
                end else begin
                    a_ra  = r_cur;
                end
            end
            OP_T_ACC: begin
                n_res_start = '0;
                n_res_len   = '0;
                n_res_line  = r_line;
                if (t_hit) begin
                    n_res_has   = 1'b1;
                    n_res_st    = ST_MATCH;
                    n_res_start = t_start[9:0];
                    n_res_len   = t_len[9:0];
                    n_matched   = 1'b1;
                end else if (r_sat) begin
                    n_res_has = 1'b1;
                    n_res_st  = ST_SATURATED;
                    n_matched = 1'b1;
                end
                if (r_lbs < LW'(MAX_LINE)) begin
                    n_lbs = r_lbs + 1'b1;
                end
                if (r_last) begin
                    if (!t_hit && !r_sat && !r_matched) begin
                        n_res_has = 1'b1;
                        n_res_st  = ST_NO_MATCH;
                    end
                    n_cur     = '0;
                    n_lbs     = '0;
                    n_matched = 1'b0;
                end
            end
            OP_EMIT: begin
                n_ov      = 1'b1;
                n_o_st    = r_res_st;
                n_o_start = r_res_start;
                n_o_len   = r_res_len;
                n_o_line  = r_res_line;
                n_res_has = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_count    <= (NW+1)'(1);
            r_cursor   <= '0;
            r_depth    <= '0;
            r_dropping <= 1'b0;
            r_dstat    <= ST_STORED;
            r_built    <= 1'b0;
            r_cur      <= '0;
            r_lbs      <= '0;
            r_matched  <= 1'b0;
            r_line     <= '0;
            r_res_has  <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_clr      <= n_clr;
            r_count    <= n_count;
            r_cursor   <= n_cursor;
            r_depth    <= n_depth;
            r_dropping <= n_dropping;
            r_dstat    <= n_dstat;
            r_built    <= n_built;
            r_cur      <= n_cur;
            r_lbs      <= n_lbs;
            r_matched  <= n_matched;
            r_line     <= n_line;
            r_res_has  <= n_res_has;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_last      <= n_last;
        r_search    <= n_search;
        r_sat       <= n_sat;
        r_sym       <= n_sym;
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_n         <= n_n;
        r_f         <= n_f;
        r_nb        <= n_nb;
        r_acc_n     <= n_acc_n;
        r_res_st    <= n_res_st;
        r_res_start <= n_res_start;
        r_res_len   <= n_res_len;
        r_res_line  <= n_res_line;
        r_o_st      <= n_o_st;
        r_o_start   <= n_o_start;
        r_o_len     <= n_o_len;
        r_o_line    <= n_o_line;
    end

    always_comb begin
        o_stat.clr_done     = (r_clr == (GW+1)'(NSLOT));
        o_stat.act          = i_action;
        o_stat.last         = r_last;
        o_stat.built        = r_built;
        o_stat.dropping     = r_dropping;
        o_stat.cursor_zero  = (r_cursor == '0);
        o_stat.b_ok         = b_ok_in;
        o_stat.sym_last     = (r_sym == SW'(ALPHABET - 1));
        o_stat.head_lt_tail = (r_head < r_tail);
        o_stat.k_zero       = (p_rd == '0);
        o_stat.has_result   = n_res_has;
        o_stat.out_free     = !r_ov || i_out_ready;
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_st;
    assign o_match_start  = r_o_start;
    assign o_match_length = r_o_len;
    assign o_line_number  = r_o_line;

endmodule

// File: hdl/aho_corasick_first_match_core.sv
// ---------------------------------------------------------------------------
// aho_corasick_first_match_core
// Multi-pattern byte scanner: trie insert, automaton build, first match/line.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries items {action, data_byte, last}; o_out carries results
//   {status, match_start, match_length, line_number}. Both are valid/ready.
//   Pattern bytes: goto read, node allocate, finish; the allocate step is
//   skipped while the pattern is being dropped or the byte is out of range.
//   Build: root row, then per trie node a BFS pop, its fail link (with a
//   fail-goto read when its parent is not the root) and a walk of its full
//   goto row through one shared goto memory (one write, two reads).
//   Text bytes: goto read, accept-flag read and update, chained through the
//   synchronous goto read.
//   One item is worked on at a time; an item that gives a result then
//   hands it to the output register in an emit step.
// Reset: a clearing pass over all MAX_NODES*ALPHABET goto slots zeroes the
//   goto table (and the accept flags alongside) before i_in.ready rises.
// Stall: a pending result sits in the output register; the next item is
//   accepted and worked on, and waits for its own result slot only when
//   it has a result to give.
// ---------------------------------------------------------------------------
module aho_corasick_first_match_core #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 256,
    parameter int MAX_LINE  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acfm_in_if.sink     i_in,
    acfm_out_if.source  o_out
);
    import acfm_pkg::*;

`include "aho_corasick_first_match_core_defines.svh"

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one state per memory step of each item kind
    acfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // memories, cursors and the result/output registers
    acfm_datapath #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET),
        .MAX_LINE  (MAX_LINE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_in.action),
        .i_data_byte    (i_in.data_byte),
        .i_last         (i_in.last),
        .i_out_ready    (o_out.ready),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_match_start  (o_out.match_start),
        .o_match_length (o_out.match_length),
        .o_line_number  (o_out.line_number)
    );

    assign i_in.ready = cmd.in_ready;

    // an accepted item always keeps the block busy in the cycle after it
    `ACFM_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready right after accept")
    // a match always carries a nonzero pattern length
    `ACFM_ASSERT_NOW(a_match_len, o_out.valid && o_out.status == ST_MATCH, o_out.match_length != 10'd0, "match with zero length")
    // pattern, build and order results carry no line number
    `ACFM_ASSERT_NOW(a_no_line, o_out.valid && (o_out.status == ST_STORED || o_out.status == ST_FULL || o_out.status == ST_BUILT || o_out.status == ST_ORDER), o_out.line_number == 32'd0, "line number on non-text result")

endmodule

// File: tb/sv/aho_corasick_first_match_core_test.sv
// ---------------------------------------------------------------------------
// First-match scanner testbench
// Feeds directed and random pattern, build and text items through the
// valid/ready channels and checks every result against a local automaton or a typed-in status.
// ---------------------------------------------------------------------------
module aho_corasick_first_match_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import acfm_pkg::*;

    localparam int NODES = 1024;
    localparam int ALPH  = 256;
    localparam int LMAX  = 1024;
    localparam logic [1:0] ACT_BAD = 2'd3;   // undefined action

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  start;
        logic [9:0]  length;
        logic [31:0] line;
    } t_scan_res;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
        logic       last;
        logic       typed;      // expected status typed in below
        logic [2:0] status;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    acfm_in_if  in_ch();
    acfm_out_if out_ch();

    aho_corasick_first_match_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- automaton shadow ----------------
    logic [9:0]  go_tab [0:NODES*ALPH-1];
    logic [9:0]  fail_of [0:NODES-1];
    logic [9:0]  parent_of [0:NODES-1];
    logic [7:0]  byte_of [0:NODES-1];
    logic [10:0] depth_of [0:NODES-1];
    logic        accept_of [0:NODES-1];
    logic [10:0] hit_len [0:NODES-1];
    logic [9:0]  bfs_q [0:NODES-1];
    int          node_cnt;
    int          cursor;
    bit          is_built;
    int          cur_node;
    int          line_pos;
    bit          line_done;
    logic [31:0] line_cnt;
    bit          dropping;
    logic [2:0]  drop_st;

    t_scan_res   results_due[$];
    int          errors = 0;
    logic [2:0]  last_pred_st;

    int snd_idle = 16;
    int rcv_idle = 68;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    int sent = 0;

    // stored patterns, used to seed text lines with real hits
    logic [7:0] pat_mem [0:8191];
    int         pat_off [0:1023];
    int         pat_len [0:1023];
    int         n_pats = 0;

    function automatic void shadow_reset();
        for (int i = 0; i < NODES*ALPH; i++) go_tab[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            accept_of[i] = 1'b0;
            depth_of[i]  = '0;
            hit_len[i]   = '0;
        end
        node_cnt = 1;
        cursor = 0;
        is_built = 0;
        cur_node = 0;
        line_pos = 0;
        line_done = 0;
        line_cnt = '0;
        dropping = 0;
        drop_st = ST_STORED;
    endfunction

    // BFS over the trie: fail links, goto completion, inherited acceptance
    function automatic void build_links();
        int head;
        int tail;
        int n;
        int k;
        int f;
        int ch;
        head = 0;
        tail = 0;
        for (int a = 0; a < ALPH; a++) begin
            ch = int'(go_tab[a]);
            if (ch != 0 && tail < NODES) begin
                fail_of[ch] = '0;
                bfs_q[tail] = ch[9:0];
                tail++;
            end
        end
        while (head < tail) begin
            n = int'(bfs_q[head]);
            head++;
            k = int'(parent_of[n]);
            f = 0;
            if (k != 0) f = int'(go_tab[int'(fail_of[k])*ALPH + int'(byte_of[n])]);
            fail_of[n] = f[9:0];
            if (!accept_of[n] && accept_of[f]) begin
                accept_of[n] = 1'b1;
                hit_len[n] = hit_len[f];
            end
            for (int a = 0; a < ALPH; a++) begin
                if (go_tab[n*ALPH + a] != 0) begin
                    if (tail < NODES) begin
                        bfs_q[tail] = go_tab[n*ALPH + a];
                        tail++;
                    end
                end else begin
                    go_tab[n*ALPH + a] = go_tab[f*ALPH + a];
                end
            end
        end
    endfunction

    function automatic t_scan_res mk_res(logic [2:0] st, int s, int l, logic [31:0] ln);
        t_scan_res r;
        r.status = st;
        r.start  = s[9:0];
        r.length = l[9:0];
        r.line   = ln;
        return r;
    endfunction

    function automatic bit scan_predict(input logic [1:0] act, input logic [7:0] db,
                                        input logic lst, output t_scan_res r);
        int slot;
        int ch;
        int idx;
        int len;
        bit got;
        logic [2:0] st;
        r = mk_res(ST_ORDER, 0, 0, 0);
        if (act == ACT_PATTERN) begin
            if (is_built) return 1'b1;
            if (!dropping) begin
                slot = cursor*ALPH + int'(db);
                ch = int'(go_tab[slot]);
                if (ch == 0) begin
                    if (node_cnt >= NODES) begin
                        dropping = 1;
                        drop_st = ST_FULL;
                    end else begin
                        ch = node_cnt;
                        node_cnt++;
                        go_tab[slot] = ch[9:0];
                        parent_of[ch] = cursor[9:0];
                        byte_of[ch] = db;
                        depth_of[ch] = depth_of[cursor] + 11'd1;
                    end
                end
                if (!dropping) cursor = ch;
            end
            if (!lst) return 1'b0;
            st = ST_STORED;
            if (dropping) st = drop_st;
            else begin
                accept_of[cursor] = 1'b1;
                hit_len[cursor] = depth_of[cursor];
            end
            cursor = 0;
            dropping = 0;
            r = mk_res(st, 0, 0, 0);
            return 1'b1;
        end
        if (act == ACT_BUILD) begin
            if (is_built || cursor != 0 || dropping) return 1'b1;
            build_links();
            is_built = 1;
            r = mk_res(ST_BUILT, 0, 0, 0);
            return 1'b1;
        end
        if (act == ACT_TEXT) begin
            got = 0;
            if (!is_built) return 1'b1;
            if (line_pos == 0 && line_cnt != 32'hFFFF_FFFF) line_cnt++;
            idx = line_pos;
            if (!line_done) begin
                if (idx >= LMAX) begin
                    line_done = 1;
                    got = 1;
                    r = mk_res(ST_SATURATED, 0, 0, line_cnt);
                end else begin
                    cur_node = int'(go_tab[cur_node*ALPH + int'(db)]);
                    if (accept_of[cur_node]) begin
                        len = int'(hit_len[cur_node]);
                        line_done = 1;
                        got = 1;
                        r = mk_res(ST_MATCH, (len <= idx+1) ? idx+1-len : 0, len, line_cnt);
                    end
                end
            end
            if (line_pos < LMAX) line_pos++;
            if (lst) begin
                if (!got && !line_done) begin
                    got = 1;
                    r = mk_res(ST_NO_MATCH, 0, 0, line_cnt);
                end
                cur_node = 0;
                line_pos = 0;
                line_done = 0;
            end
            return got;
        end
        return 1'b1;
    endfunction

    // ---------------- sender ----------------
    task automatic offer_item(input logic [1:0] act, input logic [7:0] db, input logic lst,
                              input logic typed = 1'b0, input logic [2:0] typed_st = '0);
        t_scan_res r;
        bit has;
        while ($urandom_range(0, 99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= db;
        in_ch.last      <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        has = scan_predict(act, db, lst, r);
        if (typed) begin
            // hand-written value stands in for the shadow's
            has = 1'b1;
            r = mk_res(typed_st, 0, 0, 0);
        end
        if (has) results_due.push_back(r);
        last_pred_st = r.status;
        sent++;
        if (sent == 480) begin
            snd_idle = 68;
            rcv_idle = 16;
        end else if (sent == 960) begin
            snd_idle = 0;
            rcv_idle = 0;
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    t_stim_row pre_rows[$];
    t_stim_row post_rows[$];

    function automatic t_stim_row row(logic [1:0] a, logic [7:0] d, logic l,
                                      logic t = 1'b0, logic [2:0] s = '0);
        t_stim_row x;
        x.act = a; x.data = d; x.last = l; x.typed = t; x.status = s;
        return x;
    endfunction

    task automatic walk_rows(input t_stim_row rows[$]);
        foreach (rows[i])
            offer_item(rows[i].act, rows[i].data, rows[i].last, rows[i].typed, rows[i].status);
    endtask

    task automatic keep_pattern(input logic [7:0] buf_b [0:7], input int n);
        if (n_pats < 1024 && (n_pats == 0 || pat_off[n_pats-1] + pat_len[n_pats-1] + n < 8192))
        begin
            pat_off[n_pats] = (n_pats == 0) ? 0 : pat_off[n_pats-1] + pat_len[n_pats-1];
            pat_len[n_pats] = n;
            for (int i = 0; i < n; i++) pat_mem[pat_off[n_pats] + i] = buf_b[i];
            n_pats++;
        end
    endtask

    initial begin
        logic [7:0] pbuf [0:7];
        logic [7:0] lbuf [0:63];
        int plen;
        int llen;
        int full_hits;
        int p;
        int at;

        in_ch.valid = 1'b0;
        in_ch.action = ACT_PATTERN;
        in_ch.data_byte = '0;
        in_ch.last = 1'b0;
        shadow_reset();

        // pre-build table: ordering errors, byte extremes, overlapping patterns
        pre_rows.push_back(row(ACT_TEXT, "a", 1'b1, 1'b1, ST_ORDER));
        pre_rows.push_back(row(ACT_BAD, 8'hFF, 1'b1, 1'b1, ST_ORDER));
        pre_rows.push_back(row(ACT_PATTERN, 8'h00, 1'b1, 1'b1, ST_STORED));
        pre_rows.push_back(row(ACT_PATTERN, 8'hFF, 1'b1, 1'b1, ST_STORED));
        pre_rows.push_back(row(ACT_PATTERN, "h", 1'b0));
        pre_rows.push_back(row(ACT_PATTERN, "e", 1'b1, 1'b1, ST_STORED));
        pre_rows.push_back(row(ACT_PATTERN, "s", 1'b0));
        pre_rows.push_back(row(ACT_PATTERN, "h", 1'b0));
        pre_rows.push_back(row(ACT_PATTERN, "e", 1'b1, 1'b1, ST_STORED));
        pre_rows.push_back(row(ACT_PATTERN, "h", 1'b0));
        pre_rows.push_back(row(ACT_PATTERN, "e", 1'b0));
        // build while a pattern is open
        pre_rows.push_back(row(ACT_BUILD, 8'h00, 1'b0, 1'b1, ST_ORDER));
        pre_rows.push_back(row(ACT_PATTERN, "r", 1'b0));
        pre_rows.push_back(row(ACT_PATTERN, "s", 1'b1, 1'b1, ST_STORED));

        // post-build table
        post_rows.push_back(row(ACT_BUILD, 8'hAA, 1'b1, 1'b1, ST_BUILT));
        post_rows.push_back(row(ACT_BUILD, 8'h55, 1'b0, 1'b1, ST_ORDER));
        post_rows.push_back(row(ACT_PATTERN, "x", 1'b1, 1'b1, ST_ORDER));
        post_rows.push_back(row(ACT_TEXT, "u", 1'b0));
        post_rows.push_back(row(ACT_TEXT, "s", 1'b0));
        post_rows.push_back(row(ACT_TEXT, "h", 1'b0));
        post_rows.push_back(row(ACT_TEXT, "e", 1'b0));
        post_rows.push_back(row(ACT_TEXT, "r", 1'b0));
        post_rows.push_back(row(ACT_TEXT, "s", 1'b1));
        post_rows.push_back(row(ACT_TEXT, 8'h00, 1'b1));
        post_rows.push_back(row(ACT_TEXT, 8'hFF, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        walk_rows(pre_rows);

        // random patterns until the store runs full and keeps refusing
        full_hits = 0;
        while (!(node_cnt >= NODES && full_hits >= 6)) begin
            if ($urandom_range(0, 99) < 3) begin
                offer_item($urandom_range(0, 1) ? ACT_TEXT : ACT_BAD,
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                continue;
            end
            plen = $urandom_range(1, 8);
            for (int i = 0; i < plen; i++) begin
                if ($urandom_range(0, 3) == 0) pbuf[i] = 8'($urandom_range("a", "c"));
                else pbuf[i] = 8'($urandom_range(0, 255));
                offer_item(ACT_PATTERN, pbuf[i], i == plen - 1);
            end
            if (last_pred_st == ST_FULL) full_hits++;
            else if (last_pred_st == ST_STORED) keep_pattern(pbuf, plen);
        end

        // sender waits out every pending result before the long build
        drain_results();
        walk_rows(post_rows);

        // random text lines, many carrying a stored pattern
        for (int ln = 0; ln < 35; ln++) begin
            llen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int i = 0; i < llen; i++)
                lbuf[i] = ($urandom_range(0, 1)) ? 8'($urandom_range("a", "c"))
                                                 : 8'($urandom_range(0, 255));
            if (n_pats > 0 && $urandom_range(0, 99) < 60) begin
                p = $urandom_range(0, n_pats - 1);
                at = $urandom_range(0, llen - 1);
                for (int i = 0; i < pat_len[p] && at + i < 64; i++)
                    lbuf[at + i] = pat_mem[pat_off[p] + i];
                if (at + pat_len[p] > llen) llen = (at + pat_len[p] > 64) ? 64 : at + pat_len[p];
            end
            if (ln == 15) hold_asks++;   // receiver stalls, block backs up
            if ($urandom_range(0, 99) < 4)
                offer_item($urandom_range(0, 1) ? ACT_PATTERN : ACT_BAD,
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            for (int i = 0; i < llen; i++)
                offer_item(ACT_TEXT, lbuf[i], i == llen - 1);
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin
        t_scan_res want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    $error("result with nothing expected: status %0d", out_ch.status);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.match_start !== want.start) begin
                        $error("match_start: expected %0d, got %0d", want.start,
                               out_ch.match_start);
                        errors++;
                    end
                    if (out_ch.match_length !== want.length) begin
                        $error("match_length: expected %0d, got %0d", want.length,
                               out_ch.match_length);
                        errors++;
                    end
                    if (out_ch.line_number !== want.line) begin
                        $error("line_number: expected %0d, got %0d", want.line,
                               out_ch.line_number);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (hold_done != hold_asks) begin
                hold_done <= hold_asks;
                hold_left <= 400;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    // clearing pass plus a full-store build dominate; ample margin on top
    initial begin
        #(60_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
